FILE: rtl/core/hebp_pkg.sv
// ============================================================================
// Huffman encoder bit packer package
// Shared widths, request codes and the command record passed front to back.
// ============================================================================
`default_nettype none

package hebp_pkg;

    localparam int CODE_W           = 32;   // width of a stored code
    localparam int LEN_W            = 6;    // width of a code length
    localparam int SYM_W            = 8;    // width of a symbol
    localparam int REQ_W            = 2;    // width of the request kind
    localparam int BYTE_W           = 8;    // width of a packed output byte
    localparam int SYM_DEPTH        = 256;  // entries in the code table
    localparam int IN_TDATA_W       = 48;   // symbol, length and code, byte padded
    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int Q_DEPTH          = 2;    // command queue entries

    localparam logic [2:0] TOP_POS = 3'd7;  // bit that takes the next code bit

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2
    } t_req;

    // One unit of work for the packer: either a flush or a code to append.
    typedef struct packed {
        logic              flush;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/hebp_front.sv
// ============================================================================
// Huffman encoder front end
// Accepts requests, keeps the code table and turns encodes and flushes into commands.
// ============================================================================
`default_nettype none

module hebp_front #(
    parameter int MAX_CODE_LEN = hebp_pkg::DEF_MAX_CODE_LEN
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [hebp_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic [hebp_pkg::REQ_W-1:0]        s_tuser,
    output logic                                   o_q_valid,
    output hebp_pkg::t_cmd                         o_q_cmd,
    input  wire logic                              i_q_ready
);

    localparam int LEN_BOUND = (MAX_CODE_LEN < hebp_pkg::CODE_W) ?
                               MAX_CODE_LEN : hebp_pkg::CODE_W;

    logic [hebp_pkg::SYM_W-1:0]  sym;
    logic [hebp_pkg::LEN_W-1:0]  len_in;
    logic [hebp_pkg::LEN_W-1:0]  len_sat;
    logic [hebp_pkg::CODE_W-1:0] code_in;
    hebp_pkg::t_req              req;
    logic                        accept;
    logic                        is_load;
    logic                        is_work;
    logic                        pend_free;
    logic [hebp_pkg::LEN_W-1:0]  eff_len;

    logic [hebp_pkg::CODE_W-1:0] mem_code [hebp_pkg::SYM_DEPTH];
    logic [hebp_pkg::LEN_W-1:0]  mem_len  [hebp_pkg::SYM_DEPTH];
    logic [hebp_pkg::SYM_DEPTH-1:0] r_len_vld;

    logic                        r_pv;
    logic                        r_pflush;
    logic                        r_rd_vld;
    logic [hebp_pkg::LEN_W-1:0]  r_rd_len;
    logic [hebp_pkg::CODE_W-1:0] r_rd_code;

    assign sym     = s_tdata[7:0];
    assign len_in  = s_tdata[13:8];
    assign code_in = s_tdata[45:14];
    assign req     = hebp_pkg::t_req'(s_tuser);
    assign len_sat = (len_in > hebp_pkg::LEN_W'(LEN_BOUND)) ?
                     hebp_pkg::LEN_W'(LEN_BOUND) : len_in;

    always_comb begin
        is_load = 1'b0;
        is_work = 1'b0;
        unique case (req)
            hebp_pkg::REQ_LOAD:   is_load = 1'b1;
            hebp_pkg::REQ_ENCODE: is_work = 1'b1;
            hebp_pkg::REQ_FLUSH:  is_work = 1'b1;
            default: begin
            end
        endcase
    end

    // An entry never loaded reads as length zero and so is dropped here.
    assign eff_len   = r_rd_vld ? r_rd_len : '0;
    assign o_q_valid = r_pv && (r_pflush || (eff_len != '0));
    assign o_q_cmd   = '{flush: r_pflush, len: eff_len, code: r_rd_code};
    assign pend_free = !r_pv || !o_q_valid || i_q_ready;
    assign s_tready  = pend_free;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (accept && is_load) begin
            mem_code[sym] <= code_in;
            mem_len[sym]  <= len_sat;
        end
        if (accept) begin
            r_rd_code <= mem_code[sym];
            r_rd_len  <= mem_len[sym];
            r_rd_vld  <= r_len_vld[sym];
            r_pflush  <= (req == hebp_pkg::REQ_FLUSH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= '0;
            r_pv      <= 1'b0;
        end else begin
            if (accept && is_load) begin
                r_len_vld[sym] <= 1'b1;
            end
            if (accept) begin
                r_pv <= is_work;
            end else if (pend_free) begin
                r_pv <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hebp_queue.sv
// ============================================================================
// Huffman encoder command queue
// Two-entry queue that decouples the table lookup from the bit packer.
// ============================================================================
`default_nettype none

module hebp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  hebp_pkg::t_cmd      i_in_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output hebp_pkg::t_cmd      o_out_cmd,
    input  wire logic           i_out_ready
);

    localparam int PTR_W = $clog2(hebp_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(hebp_pkg::Q_DEPTH + 1);

    hebp_pkg::t_cmd   r_ent [hebp_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_in_ready  = (r_cnt != CNT_W'(hebp_pkg::Q_DEPTH));
    assign o_out_valid = (r_cnt != '0);
    assign o_out_cmd   = r_ent[r_rp];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= i_in_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(hebp_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_W'(hebp_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hebp_back.sv
// ============================================================================
// Huffman encoder bit packer back end
// Appends left-aligned codes to the byte accumulator, one byte per cycle while the output is free.
// ============================================================================
`default_nettype none

module hebp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  hebp_pkg::t_cmd                     i_q_cmd,
    output logic                               o_q_ready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [hebp_pkg::BYTE_W-1:0]        m_tdata,
    output logic                               m_tlast
);

    logic                          r_busy;
    logic                          r_flush;
    logic [hebp_pkg::LEN_W-1:0]    r_rem;
    logic [hebp_pkg::CODE_W-1:0]   r_code;
    logic [hebp_pkg::BYTE_W-1:0]   r_acc;
    logic [2:0]                    r_pos;
    logic                          r_ov;
    logic [hebp_pkg::BYTE_W-1:0]   r_ob;
    logic                          r_ol;

    logic                          out_free;
    logic                          step;
    logic                          emit_now;
    logic [3:0]                    cap;
    logic [hebp_pkg::BYTE_W-1:0]   merged;
    logic [hebp_pkg::CODE_W-1:0]   code_sh;
    logic [hebp_pkg::LEN_W-1:0]    rem_after;
    logic                          fills;

    assign out_free  = !r_ov || m_tready;
    assign step      = r_busy && out_free;
    assign o_q_ready = !r_busy;
    assign cap       = {1'b0, r_pos} + 4'd1;
    // Code bits past the remaining count are zero, so no masking is needed.
    assign merged    = r_acc | (r_code[hebp_pkg::CODE_W-1 -: hebp_pkg::BYTE_W] >> (3'd7 - r_pos));
    assign code_sh   = r_code << cap;
    assign fills     = ({1'b0, r_rem} >= (hebp_pkg::LEN_W + 1)'(cap));
    assign rem_after = r_rem - hebp_pkg::LEN_W'(cap);
    // A byte leaves on a step that fills the accumulator or flushes pending bits.
    assign emit_now  = step && (r_flush ? (r_pos != hebp_pkg::TOP_POS) : fills);

    assign m_tvalid = r_ov;
    assign m_tdata  = r_ob;
    assign m_tlast  = r_ol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_acc  <= '0;
            r_pos  <= hebp_pkg::TOP_POS;
            r_ov   <= 1'b0;
        end else begin
            if (emit_now) begin
                r_ov <= 1'b1;
            end else if (m_tready) begin
                r_ov <= 1'b0;
            end
            if (!r_busy && i_q_valid) begin
                r_busy  <= 1'b1;
                r_flush <= i_q_cmd.flush;
                r_rem   <= i_q_cmd.len;
                // Left-align the code so its first bit sits in the top bit.
                r_code  <= i_q_cmd.code << (hebp_pkg::LEN_W'(hebp_pkg::CODE_W) - i_q_cmd.len);
            end else if (step) begin
                if (r_flush) begin
                    if (r_pos != hebp_pkg::TOP_POS) begin
                        r_ob <= r_acc;
                        r_ol <= 1'b1;
                    end
                    r_acc  <= '0;
                    r_pos  <= hebp_pkg::TOP_POS;
                    r_busy <= 1'b0;
                end else if (fills) begin
                    r_ob <= merged;
                    if (rem_after < hebp_pkg::LEN_W'(hebp_pkg::BYTE_W)) begin
                        // The tail is shorter than a byte: park it and finish.
                        r_ol   <= 1'b1;
                        r_acc  <= code_sh[hebp_pkg::CODE_W-1 -: hebp_pkg::BYTE_W];
                        r_pos  <= hebp_pkg::TOP_POS - rem_after[2:0];
                        r_busy <= 1'b0;
                    end else begin
                        r_ol   <= 1'b0;
                        r_acc  <= '0;
                        r_pos  <= hebp_pkg::TOP_POS;
                        r_rem  <= rem_after;
                        r_code <= code_sh;
                    end
                end else begin
                    r_acc  <= merged;
                    r_pos  <= r_pos - r_rem[2:0];
                    r_busy <= 1'b0;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_empty_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && !r_flush && (r_rem == '0)))
        else $error("packer holds an encode command with no bits");

    a_acc_low_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc & 8'((9'd2 << r_pos) - 9'd1)) == 8'd0)
        else $error("accumulator has bits at or below the fill position");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_flush && out_free) |=> (r_pos == hebp_pkg::TOP_POS && r_acc == '0))
        else $error("flush did not clear the packing state");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/huffman_encode_bit_packer.sv
// Path: an accepted encode or flush is held in the front end's read register,
// then in the command queue, then in the packer; each byte waits in the
// output register. The packer takes a new command only once it is idle
// again and stalls while a byte waits; loads never leave the front end.
// Reset: synchronous active low; packing position returns to bit 7 and all
// table lengths read as zero immediately, with no clearing pass.
// ============================================================================
// Huffman encoder bit packer
// Table-driven Huffman encoder for byte symbols with an MSB-first byte packer.
// ============================================================================
`default_nettype none

module huffman_encode_bit_packer #(
    parameter int MAX_CODE_LEN = hebp_pkg::DEF_MAX_CODE_LEN
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Request stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata, from bit 0 up: symbol [7:0], code_len [13:8],
    // code_bits [45:14], zero padding [47:46].
    input  wire logic [hebp_pkg::IN_TDATA_W-1:0] s_tdata,
    // s_tuser: req_type [1:0] (load, encode, flush).
    input  wire logic [hebp_pkg::REQ_W-1:0]      s_tuser,
    // Packed byte stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: out_byte [7:0], earliest code bit in bit 7.
    output logic [hebp_pkg::BYTE_W-1:0]          m_tdata,
    // m_tlast marks the final byte produced by one request transaction.
    output logic                                 m_tlast
);

    // The front end owns the code table. Loads are absorbed there; encodes
    // and flushes become commands once the table read has completed. Encodes
    // of a symbol whose length is zero produce no command at all.
    logic           fq_valid;
    logic           fq_ready;
    hebp_pkg::t_cmd fq_cmd;

    // The queue lets the front keep accepting while the packer drains a long
    // code or waits on the output side.
    logic           qb_valid;
    logic           qb_ready;
    hebp_pkg::t_cmd qb_cmd;

    hebp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .o_q_valid (fq_valid),
        .o_q_cmd   (fq_cmd),
        .i_q_ready (fq_ready)
    );

    hebp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (fq_valid),
        .i_in_cmd    (fq_cmd),
        .o_in_ready  (fq_ready),
        .o_out_valid (qb_valid),
        .o_out_cmd   (qb_cmd),
        .i_out_ready (qb_ready)
    );

    // The back end packs bits and owns the output register, so a finished
    // byte can wait for the sink while new requests keep flowing in.
    hebp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (qb_valid),
        .i_q_cmd   (qb_cmd),
        .o_q_ready (qb_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
